// File: rtl/apd_pkg.sv
// ----------------------------------------------------------------------------
// apd_pkg
// Shared widths, event codes, register indexes and types for the absolute
// pointer event decoder.
// ----------------------------------------------------------------------------
package apd_pkg;

    localparam int TYPE_W   = 16;
    localparam int CODE_W   = 16;
    localparam int VALUE_W  = 32;
    localparam int SCREEN_W = 14;
    localparam int AMAX_W   = 16;
    localparam int POS_W    = 14;
    localparam int MASK_W   = 6;
    localparam int PROD_W   = AMAX_W + SCREEN_W;
    localparam int STEP_W   = $clog2(POS_W);
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [TYPE_W-1:0] EV_SYNC = 16'h0000;
    localparam logic [TYPE_W-1:0] EV_KEY  = 16'h0001;
    localparam logic [TYPE_W-1:0] EV_ABS  = 16'h0003;

    localparam logic [CODE_W-1:0] ABS_X = 16'h0000;
    localparam logic [CODE_W-1:0] ABS_Y = 16'h0001;

    localparam logic [CODE_W-1:0] KEY_LEFT        = 16'h0110;
    localparam logic [CODE_W-1:0] KEY_RIGHT       = 16'h0111;
    localparam logic [CODE_W-1:0] KEY_MIDDLE      = 16'h0112;
    localparam logic [CODE_W-1:0] KEY_SCROLL_DOWN = 16'h0150;
    localparam logic [CODE_W-1:0] KEY_SCROLL_UP   = 16'h0151;

    localparam int MASK_BIT_LEFT        = 0;
    localparam int MASK_BIT_RIGHT       = 1;
    localparam int MASK_BIT_MIDDLE      = 2;
    localparam int MASK_BIT_UNUSED      = 3;
    localparam int MASK_BIT_SCROLL_UP   = 4;
    localparam int MASK_BIT_SCROLL_DOWN = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAX_X    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAX_Y    = 8'd3;

    localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 14'd1024;
    localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 14'd768;
    localparam logic [AMAX_W-1:0]   RST_AXIS_MAX      = 16'd32767;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCALE
    } apd_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } apd_scale_phase_t;

    typedef struct packed {
        logic                start;
        logic [AMAX_W-1:0]   value;
        logic [SCREEN_W-1:0] screen;
        logic [AMAX_W-1:0]   amax;
    } apd_scale_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quotient;
    } apd_scale_rsp_t;

endpackage

// File: rtl/apd_ifs.sv
// ----------------------------------------------------------------------------
// apd_ifs
// Valid/ready channel interfaces for input events, pointer reports and
// register writes.
// ----------------------------------------------------------------------------
interface apd_event_if
    import apd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TYPE_W-1:0]  event_type;
    logic [CODE_W-1:0]  event_code;
    logic [VALUE_W-1:0] event_value;

    modport source (output valid, output event_type, output event_code,
                    output event_value, input ready);
    modport sink   (input valid, input event_type, input event_code,
                    input event_value, output ready);
endinterface

interface apd_pointer_if
    import apd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0]  pointer_x;
    logic [POS_W-1:0]  pointer_y;
    logic [MASK_W-1:0] button_mask;

    modport source (output valid, output pointer_x, output pointer_y,
                    output button_mask, input ready);
    modport sink   (input valid, input pointer_x, input pointer_y,
                    input button_mask, output ready);
endinterface

interface apd_cfg_if
    import apd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/apd_scaler.sv
// ----------------------------------------------------------------------------
// apd_scaler
// Bit-serial value * screen / amax: shift-add multiply over the screen bits,
// then restoring division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apd_scaler
    import apd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  apd_scale_req_t req,
    output apd_scale_rsp_t rsp
);

    apd_scale_phase_t    phase_reg, phase_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [AMAX_W-1:0]   val_reg, val_next;
    logic [SCREEN_W-1:0] scr_reg, scr_next;
    logic [AMAX_W-1:0]   div_reg, div_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [POS_W-1:0]    q_reg, q_next;

    logic [AMAX_W:0]     trial;
    logic                ge;
    logic [AMAX_W:0]     rem_new;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

    // upper part of the product is the running remainder, lower part the
    // dividend bits still to be brought down
    assign trial   = {prod_reg[PROD_W-1 -: AMAX_W], prod_reg[POS_W-1]};
    assign ge      = (trial >= {1'b0, div_reg});
    assign rem_new = ge ? (trial - {1'b0, div_reg}) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= SC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        scr_reg  <= scr_next;
        div_reg  <= div_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        scr_next   = scr_reg;
        div_next   = div_reg;
        prod_next  = prod_reg;
        q_next     = q_reg;
        case (phase_reg)
            SC_IDLE:
            begin
                if (req.start)
                begin
                    val_next   = req.value;
                    scr_next   = req.screen;
                    div_next   = req.amax;
                    prod_next  = '0;
                    cnt_next   = '0;
                    phase_next = SC_MUL;
                end
            end
            SC_MUL:
            begin
                prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                          + (scr_reg[SCREEN_W-1] ? PROD_W'(val_reg) : '0);
                scr_next  = {scr_reg[SCREEN_W-2:0], 1'b0};
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    phase_next = SC_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SC_DIV:
            begin
                prod_next = {rem_new[AMAX_W-1:0], prod_reg[POS_W-2:0], 1'b0};
                q_next    = {q_reg[POS_W-2:0], ge};
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    phase_next = SC_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SC_DONE:
            begin
                phase_next = SC_IDLE;
            end
            default:
            begin
                phase_next = SC_IDLE;
            end
        endcase
    end

    assign rsp.done     = (phase_reg == SC_DONE);
    assign rsp.quotient = q_reg;

endmodule

// File: rtl/absolute_pointer_event_decoder.sv
// ----------------------------------------------------------------------------
// absolute_pointer_event_decoder
// Decodes absolute tablet events into a scaled pointer position and a
// button mask, reported on every sync event.
//
//   channel   dir  payload                                   role
//   events    in   event_type, event_code, event_value       input events
//   pointer   out  pointer_x, pointer_y, button_mask         sync reports
//   cfg       in   index, data                               register writes
//
// key, sync and ignored events are handled without the serial scaler, as is an
// absolute event whose axis maximum is zero
// any other absolute X or Y event starts the serial scaler, which runs 14 multiply
// steps and 14 divide steps before the result is written back
// a sync event waits while a previous report is held and not taken
// reset restores the default screen size and axis maxima and clears state
// ----------------------------------------------------------------------------
module absolute_pointer_event_decoder
    import apd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    apd_event_if.sink     events,
    apd_pointer_if.source pointer,
    apd_cfg_if.sink       cfg
);

    apd_state_t          state_reg, state_next;

    logic [SCREEN_W-1:0] screen_width_reg;
    logic [SCREEN_W-1:0] screen_height_reg;
    logic [AMAX_W-1:0]   axis_max_x_reg;
    logic [AMAX_W-1:0]   axis_max_y_reg;

    logic [POS_W-1:0]    pos_x_reg;
    logic [POS_W-1:0]    pos_y_reg;
    logic                left_reg, right_reg, middle_reg;
    logic                scroll_up_reg, scroll_down_reg;
    logic                axis_y_reg, axis_y_next;

    logic                out_valid_reg;
    logic [POS_W-1:0]    out_x_reg;
    logic [POS_W-1:0]    out_y_reg;
    logic [MASK_W-1:0]   out_mask_reg;

    logic                accept;
    logic                slot_free;
    logic                is_sync, is_key, is_abs_x, is_abs_y;
    logic [AMAX_W-1:0]   sel_amax;
    logic [SCREEN_W-1:0] sel_screen;
    logic [AMAX_W-1:0]   clamped;
    logic                zero_amax;
    logic [MASK_W-1:0]   mask_now;
    logic                level;

    apd_scale_req_t      scale_req;
    apd_scale_rsp_t      scale_rsp;

    apd_scaler u_scaler (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scale_req),
        .rsp   (scale_rsp)
    );

    assign is_sync  = (events.event_type == EV_SYNC);
    assign is_key   = (events.event_type == EV_KEY);
    assign is_abs_x = (events.event_type == EV_ABS) && (events.event_code == ABS_X);
    assign is_abs_y = (events.event_type == EV_ABS) && (events.event_code == ABS_Y);

    assign sel_amax   = is_abs_y ? axis_max_y_reg : axis_max_x_reg;
    assign sel_screen = is_abs_y ? screen_height_reg : screen_width_reg;
    assign zero_amax  = (sel_amax == '0);
    assign clamped    = (events.event_value > VALUE_W'(sel_amax))
                      ? sel_amax : events.event_value[AMAX_W-1:0];
    assign level      = (events.event_value != '0);

    assign slot_free = !out_valid_reg || pointer.ready;
    assign accept    = events.valid && events.ready;

    always_comb
    begin
        mask_now                       = '0;
        mask_now[MASK_BIT_LEFT]        = left_reg;
        mask_now[MASK_BIT_RIGHT]       = right_reg;
        mask_now[MASK_BIT_MIDDLE]      = middle_reg;
        mask_now[MASK_BIT_UNUSED]      = 1'b0;
        mask_now[MASK_BIT_SCROLL_UP]   = scroll_up_reg;
        mask_now[MASK_BIT_SCROLL_DOWN] = scroll_down_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, input ready and scaler start
    always_comb
    begin
        state_next        = state_reg;
        events.ready      = 1'b0;
        axis_y_next       = axis_y_reg;
        scale_req.start   = 1'b0;
        scale_req.value   = clamped;
        scale_req.screen  = sel_screen;
        scale_req.amax    = sel_amax;
        case (state_reg)
            ST_IDLE:
            begin
                // a sync transaction needs room in the output register
                events.ready = slot_free || !is_sync;
                // absolute events are never held back in idle
                if (events.valid && (is_abs_x || is_abs_y) && !zero_amax)
                begin
                    scale_req.start = 1'b1;
                    axis_y_next     = is_abs_y;
                    state_next      = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (scale_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        axis_y_reg <= axis_y_next;
        if (accept && is_sync)
        begin
            out_x_reg    <= pos_x_reg;
            out_y_reg    <= pos_y_reg;
            out_mask_reg <= mask_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            axis_max_x_reg    <= RST_AXIS_MAX;
            axis_max_y_reg    <= RST_AXIS_MAX;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            left_reg          <= 1'b0;
            right_reg         <= 1'b0;
            middle_reg        <= 1'b0;
            scroll_up_reg     <= 1'b0;
            scroll_down_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg.data[SCREEN_W-1:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg.data[SCREEN_W-1:0];
                    REG_AXIS_MAX_X:    axis_max_x_reg    <= cfg.data[AMAX_W-1:0];
                    REG_AXIS_MAX_Y:    axis_max_y_reg    <= cfg.data[AMAX_W-1:0];
                    default:           ;
                endcase
            end

            if (accept && is_sync)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pointer.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                if (is_sync)
                begin
                    scroll_up_reg   <= 1'b0;
                    scroll_down_reg <= 1'b0;
                end
                else if (is_key)
                begin
                    case (events.event_code)
                        KEY_LEFT:        left_reg        <= level;
                        KEY_RIGHT:       right_reg       <= level;
                        KEY_MIDDLE:      middle_reg      <= level;
                        KEY_SCROLL_DOWN: scroll_down_reg <= 1'b1;
                        KEY_SCROLL_UP:   scroll_up_reg   <= 1'b1;
                        default:         ;
                    endcase
                end
                else if (zero_amax && is_abs_x)
                begin
                    pos_x_reg <= '0;
                end
                else if (zero_amax && is_abs_y)
                begin
                    pos_y_reg <= '0;
                end
            end

            if ((state_reg == ST_SCALE) && scale_rsp.done)
            begin
                if (axis_y_reg)
                begin
                    pos_y_reg <= scale_rsp.quotient;
                end
                else
                begin
                    pos_x_reg <= scale_rsp.quotient;
                end
            end
        end
    end

    assign cfg.ready           = 1'b1;
    assign pointer.valid       = out_valid_reg;
    assign pointer.pointer_x   = out_x_reg;
    assign pointer.pointer_y   = out_y_reg;
    assign pointer.button_mask = out_mask_reg;

endmodule

// File: rtl/apd_checker.sv
// ----------------------------------------------------------------------------
// apd_checker
// Port-level checks for the absolute pointer event decoder, bound to the
// top level.
// ----------------------------------------------------------------------------
module apd_checker
    import apd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              ev_valid,
    input logic              ev_ready,
    input logic [TYPE_W-1:0] ev_type,
    input logic              ptr_valid,
    input logic              ptr_ready,
    input logic [POS_W-1:0]  ptr_x,
    input logic [POS_W-1:0]  ptr_y,
    input logic [MASK_W-1:0] ptr_mask
);

    logic sync_accept;
    assign sync_accept = ev_valid && ev_ready && (ev_type == EV_SYNC);

    // a report only appears after a sync transaction
    a_report_from_sync: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ptr_valid) |-> $past(sync_accept))
        else $error("pointer report without a sync transaction");

    // every sync transaction yields a report in the next cycle
    a_sync_reports: assert property (@(posedge clk) disable iff (!rst_n)
        sync_accept |=> ptr_valid)
        else $error("sync transaction produced no report");

    // the reserved mask bit is never set
    a_mask_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_valid |-> !ptr_mask[MASK_BIT_UNUSED])
        else $error("reserved button mask bit set");

    // a stalled report holds
    a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_valid && !ptr_ready |=> ptr_valid && $stable(ptr_x)
            && $stable(ptr_y) && $stable(ptr_mask))
        else $error("stalled pointer report changed");

endmodule

bind absolute_pointer_event_decoder apd_checker u_apd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (events.valid),
    .ev_ready  (events.ready),
    .ev_type   (events.event_type),
    .ptr_valid (pointer.valid),
    .ptr_ready (pointer.ready),
    .ptr_x     (pointer.pointer_x),
    .ptr_y     (pointer.pointer_y),
    .ptr_mask  (pointer.button_mask)
);
